[hdl/clr_pkg.sv]
// ----------------------------------------------------------------------------
// clr_pkg
// Shared constants, codes and types of the clipped line rasterizer.
// ----------------------------------------------------------------------------
package clr_pkg;

  // Display geometry
  localparam int DISPLAY_SIDE = 128;
  localparam int XW           = $clog2(DISPLAY_SIDE);     // pixel coordinate bits
  localparam int ROW_BYTES    = DISPLAY_SIDE / 8;
  localparam int COL_W        = $clog2(ROW_BYTES);        // byte column bits
  localparam int ROW_W        = DISPLAY_SIDE;             // one stored row, in bits

  // Command coordinate and error widths
  localparam int CW = 12;                                 // signed coordinate bits
  localparam int EW = CW + 3;                             // Bresenham error bits

  // Command codes
  typedef enum logic [1:0] {
    MODE_LINE  = 2'd0,
    MODE_RECT  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  // One on-display pixel from the walker
  typedef struct packed {
    logic          vld;
    logic [XW-1:0] x;
    logic [XW-1:0] y;
  } pix_t;

  // Walker status toward the command sequencer
  typedef struct packed {
    logic busy;
    logic fin;   // last step of the current shape, or an empty rectangle
  } walk_sts_t;

  // Row access request into the frame store
  typedef struct packed {
    logic          vld;
    logic          plot;   // read-modify-write of one bit
    logic [XW-1:0] row;
    logic [XW-1:0] bitx;
  } store_req_t;

endpackage

[hdl/clipped_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core
// Command sequencer of the 1-bit clipped line rasterizer.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result. A line takes
// max(|dx|,|dy|)+1 walker steps, whether its pixels land on the display or
// not; a rectangle takes one step per pixel of its clipped area and none
// when none of it lands on the display, a negative width included. A clear
// and a byte read take no walker steps. The pixel walker advances one
// position per cycle, and the frame store does one pipelined read-modify-write
// per plotted pixel. Clearing is done by dropping per-row valid bits, so
// there is no sweep after reset or on a clear command. The finished result
// sits in an output register, and the next request is taken while it
// waits.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_core import clr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           mode_i,
  input  logic signed [CW-1:0] x_start_i,
  input  logic signed [CW-1:0] y_start_i,
  input  logic signed [CW-1:0] x_end_i,
  input  logic signed [CW-1:0] y_end_i,
  input  logic signed [CW-1:0] rect_width_i,
  input  logic signed [CW-1:0] rect_height_i,
  input  logic                 colour_i,
  input  logic [6:0]           read_row_i,
  input  logic [3:0]           read_byte_column_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           read_data_o,
  output logic                 done_res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             accept;
  mode_e            mode;
  logic             colour_q;
  logic [COL_W-1:0] col_q;
  logic             rd_ok_q;
  logic [7:0]       res_q;
  logic             out_vld_q;
  logic [7:0]       out_data_q;
  logic             slot_free;

  pix_t             pix;
  walk_sts_t        wsts;
  store_req_t       sreq;
  logic [ROW_W-1:0] row_word;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_vld_q || out_ready_i;

  clr_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept && (mode == MODE_LINE || mode == MODE_RECT)),
    .mode_rect_i   (mode == MODE_RECT),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .pix_o         (pix),
    .sts_o         (wsts)
  );

  // Route plotted pixels or the byte read into the store
  always_comb begin
    sreq      = '0;
    sreq.vld  = pix.vld || (accept && mode == MODE_READ);
    sreq.plot = pix.vld;
    sreq.row  = pix.vld ? pix.y : read_row_i[XW-1:0];
    sreq.bitx = pix.x;
  end

  clr_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (accept && mode == MODE_CLEAR),
    .req_i      (sreq),
    .colour_i   (colour_q),
    .row_word_o (row_word)
  );

  // Command sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_LINE, MODE_RECT: state_d = S_WALK;
            MODE_CLEAR:           state_d = S_FIN;
            MODE_READ:            state_d = S_READ;
            default:              state_d = S_FIN;
          endcase
        end
      end
      S_WALK: begin
        if (wsts.fin) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_FIN;
      S_READ:  state_d = S_FIN;
      S_FIN: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && slot_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold request fields, pick the read byte, load the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      colour_q <= colour_i;
      col_q    <= read_byte_column_i[COL_W-1:0];
      rd_ok_q  <= (int'(read_row_i) < DISPLAY_SIDE) &&
                  (int'(read_byte_column_i) < ROW_BYTES);
      res_q    <= '0;
    end else if (state_q == S_READ) begin
      res_q <= rd_ok_q ? row_word[{col_q, 3'b000} +: 8] : 8'h00;
    end
    if (state_q == S_FIN && slot_free) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign read_data_o = out_data_q;
  assign done_res_o  = 1'b1;

  // No request is taken while the walker still steps a shape
  a_idle_walker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !wsts.busy)
    else $error("request taken while walker busy");

  // No pixel reaches the store outside a walk
  a_pix_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix.vld |-> (state_q == S_WALK))
    else $error("pixel plotted outside a walk");

  // A finished walk is followed by the drain cycle
  a_fin_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && wsts.fin) |=> (state_q == S_DRAIN))
    else $error("walk end not followed by drain");

endmodule

[hdl/clr_walker.sv]
// ----------------------------------------------------------------------------
// clr_walker
// Pixel walker: steps a Bresenham line or a clipped rectangle, one pixel
// position per cycle.
// ----------------------------------------------------------------------------
module clr_walker import clr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 mode_rect_i,
  input  logic signed [CW-1:0] x_start_i,
  input  logic signed [CW-1:0] y_start_i,
  input  logic signed [CW-1:0] x_end_i,
  input  logic signed [CW-1:0] y_end_i,
  input  logic signed [CW-1:0] rect_width_i,
  input  logic signed [CW-1:0] rect_height_i,
  output pix_t                 pix_o,
  output walk_sts_t            sts_o
);

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_LINE  = 2'd1;
  localparam logic [1:0] W_RECT  = 2'd2;
  localparam logic [1:0] W_EMPTY = 2'd3;

  localparam logic signed [CW:0] SIDE_S = (CW+1)'(DISPLAY_SIDE);
  localparam logic signed [CW:0] MAXC_S = (CW+1)'(DISPLAY_SIDE - 1);

  logic [1:0] state_q, state_d;

  // Line registers
  logic signed [CW-1:0] lx_q, ly_q, lx1_q, ly1_q;
  logic signed [CW:0]   dx_q, dy_q;
  logic signed [EW-1:0] err_q;
  logic                 sxn_q, syn_q;

  // Rectangle registers
  logic [XW-1:0] rx_q, ry_q, rxhi_q, rylo_q, ryhi_q;

  // Extended start operands
  logic signed [CW:0] xs_e, ys_e, xe_e, ye_e, w_e, h_e;
  logic signed [CW:0] dx_s, dy_s;
  logic signed [CW:0] xhi_e, ysum_e, ylo_e, yhi_e;
  logic signed [CW:0] xlo_c, xhi_c, ylo_c, yhi_c;
  logic               rect_empty;

  // Line step
  logic signed [EW:0]   e2;
  logic                 step_x, step_y;
  logic signed [EW-1:0] err_d;
  logic                 line_last, rect_last, on_disp;

  assign xs_e = (CW+1)'(x_start_i);
  assign ys_e = (CW+1)'(y_start_i);
  assign xe_e = (CW+1)'(x_end_i);
  assign ye_e = (CW+1)'(y_end_i);
  assign w_e  = (CW+1)'(rect_width_i);
  assign h_e  = (CW+1)'(rect_height_i);

  // Line setup: distances and directions
  assign dx_s = (xe_e > xs_e) ? (xe_e - xs_e) : (xs_e - xe_e);
  assign dy_s = (ye_e > ys_e) ? (ys_e - ye_e) : (ye_e - ys_e);

  // Rectangle setup: clip the span to the display
  assign xhi_e  = xs_e + w_e;
  assign ysum_e = ys_e + h_e;
  assign ylo_e  = h_e[CW] ? ysum_e : ys_e;
  assign yhi_e  = h_e[CW] ? ys_e : ysum_e;
  assign xlo_c  = (xs_e  < 0) ? '0 : xs_e;
  assign xhi_c  = (xhi_e > MAXC_S) ? MAXC_S : xhi_e;
  assign ylo_c  = (ylo_e < 0) ? '0 : ylo_e;
  assign yhi_c  = (yhi_e > MAXC_S) ? MAXC_S : yhi_e;
  assign rect_empty = (xlo_c > xhi_c) || (ylo_c > yhi_c);

  // Error term decisions of one line step
  assign e2     = {err_q, 1'b0};
  assign step_x = (e2 >= (EW+1)'(dy_q));
  assign step_y = (e2 <= (EW+1)'(dx_q));
  assign err_d  = err_q + (step_x ? EW'(dy_q) : EW'(0)) + (step_y ? EW'(dx_q) : EW'(0));

  assign line_last = (lx_q == lx1_q) && (ly_q == ly1_q);
  assign rect_last = (rx_q == rxhi_q) && (ry_q == ryhi_q);
  assign on_disp   = (lx_q >= 0) && ((CW+1)'(lx_q) < SIDE_S) &&
                     (ly_q >= 0) && ((CW+1)'(ly_q) < SIDE_S);

  // Present the current position
  always_comb begin
    pix_o      = '0;
    sts_o.fin  = 1'b0;
    sts_o.busy = (state_q != W_IDLE);
    state_d    = state_q;
    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          if (!mode_rect_i) begin
            state_d = W_LINE;
          end else if (rect_empty) begin
            state_d = W_EMPTY;
          end else begin
            state_d = W_RECT;
          end
        end
      end
      W_LINE: begin
        pix_o.vld = on_disp;
        pix_o.x   = lx_q[XW-1:0];
        pix_o.y   = ly_q[XW-1:0];
        sts_o.fin = line_last;
        if (line_last) begin
          state_d = W_IDLE;
        end
      end
      W_RECT: begin
        pix_o.vld = 1'b1;
        pix_o.x   = rx_q;
        pix_o.y   = ry_q;
        sts_o.fin = rect_last;
        if (rect_last) begin
          state_d = W_IDLE;
        end
      end
      W_EMPTY: begin
        sts_o.fin = 1'b1;
        state_d   = W_IDLE;
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Load at start, advance one step per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == W_IDLE && start_i) begin
      lx_q   <= x_start_i;
      ly_q   <= y_start_i;
      lx1_q  <= x_end_i;
      ly1_q  <= y_end_i;
      dx_q   <= dx_s;
      dy_q   <= dy_s;
      err_q  <= EW'(dx_s) + EW'(dy_s);
      sxn_q  <= !(xs_e < xe_e);
      syn_q  <= !(ys_e < ye_e);
      rx_q   <= xlo_c[XW-1:0];
      ry_q   <= ylo_c[XW-1:0];
      rxhi_q <= xhi_c[XW-1:0];
      rylo_q <= ylo_c[XW-1:0];
      ryhi_q <= yhi_c[XW-1:0];
    end else if (state_q == W_LINE && !line_last) begin
      err_q <= err_d;
      if (step_x) begin
        lx_q <= sxn_q ? CW'(lx_q - 1'b1) : CW'(lx_q + 1'b1);
      end
      if (step_y) begin
        ly_q <= syn_q ? CW'(ly_q - 1'b1) : CW'(ly_q + 1'b1);
      end
    end else if (state_q == W_RECT && !rect_last) begin
      if (ry_q == ryhi_q) begin
        rx_q <= XW'(rx_q + 1'b1);
        ry_q <= rylo_q;
      end else begin
        ry_q <= XW'(ry_q + 1'b1);
      end
    end
  end

endmodule

[hdl/clr_store.sv]
// ----------------------------------------------------------------------------
// clr_store
// Frame store: one memory row per display row, per-row valid bits that read
// as all ones until written, and a pipelined read-modify-write of one bit.
// ----------------------------------------------------------------------------
module clr_store import clr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clr_i,
  input  store_req_t       req_i,
  input  logic             colour_i,
  output logic [ROW_W-1:0] row_word_o
);

  logic [ROW_W-1:0]        mem [DISPLAY_SIDE];
  logic [ROW_W-1:0]        dout_q;
  logic [DISPLAY_SIDE-1:0] row_vld_q;

  logic                    s1_plot_q;
  logic [XW-1:0]           s1_row_q, s1_bit_q;

  logic                    wr_vld_q;
  logic [XW-1:0]           wr_row_q;
  logic [ROW_W-1:0]        wr_word_q;

  logic                    fwd;
  logic [ROW_W-1:0]        base_word, new_word;
  logic                    we;

  // Pick the freshest copy of the row: last write, memory, or cleared ones
  assign fwd = wr_vld_q && (wr_row_q == s1_row_q);
  assign base_word = fwd ? wr_word_q : (row_vld_q[s1_row_q] ? dout_q : '1);

  always_comb begin
    new_word           = base_word;
    new_word[s1_bit_q] = colour_i;
  end

  assign we         = s1_plot_q;
  assign row_word_o = base_word;

  // Memory: one read and one write per cycle, registered read data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[s1_row_q] <= new_word;
    end
    if (req_i.vld) begin
      dout_q <= mem[req_i.row];
    end
  end

  // Request stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_plot_q <= 1'b0;
    end else begin
      s1_plot_q <= req_i.vld && req_i.plot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      s1_row_q <= req_i.row;
      s1_bit_q <= req_i.bitx;
    end
    if (we) begin
      wr_row_q  <= s1_row_q;
      wr_word_q <= new_word;
    end
  end

  // Row valid bits and forwarding flag; a clear drops both at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      wr_vld_q  <= 1'b0;
    end else if (clr_i) begin
      row_vld_q <= '0;
      wr_vld_q  <= 1'b0;
    end else if (we) begin
      row_vld_q[s1_row_q] <= 1'b1;
      wr_vld_q            <= 1'b1;
    end
  end

endmodule

[tb/sv/clipped_line_rasterizer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core_tb
// Self-checking bench for the 1-bit clipped line rasterizer. A shadow frame
// store is updated for every accepted request (line, rectangle, clear, read)
// and the byte that each request should return is queued. Results are
// compared in order. Directed requests cover the field extremes and the
// clipping cases, a long output hold-off backs the block up, and then a
// random mix runs under several idle/stall phases.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_core_tb;
  import clr_pkg::*;

  localparam int STORE_BYTES = DISPLAY_SIDE * ROW_BYTES;

  typedef struct {
    mode_e                mode;
    logic signed [CW-1:0] x_start;
    logic signed [CW-1:0] y_start;
    logic signed [CW-1:0] x_end;
    logic signed [CW-1:0] y_end;
    logic signed [CW-1:0] rect_width;
    logic signed [CW-1:0] rect_height;
    logic                 colour;
    logic [6:0]           read_row;
    logic [3:0]           read_byte_column;
  } raster_cmd_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           mode_i = MODE_READ;
  logic signed [CW-1:0] x_start_i = '0;
  logic signed [CW-1:0] y_start_i = '0;
  logic signed [CW-1:0] x_end_i = '0;
  logic signed [CW-1:0] y_end_i = '0;
  logic signed [CW-1:0] rect_width_i = '0;
  logic signed [CW-1:0] rect_height_i = '0;
  logic                 colour_i = 1'b0;
  logic [6:0]           read_row_i = '0;
  logic [3:0]           read_byte_column_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           read_data_o;
  logic                 done_res_o;

  // Shadow frame store and the bytes still owed by the block
  logic [7:0] shadow_frame [0:STORE_BYTES-1];
  logic [7:0] owed_bytes [$];

  int err_count      = 0;
  int result_count   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int win_x          = 0;
  int win_y          = 0;

  clipped_line_rasterizer_core dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .mode_i             (mode_i),
    .x_start_i          (x_start_i),
    .y_start_i          (y_start_i),
    .x_end_i            (x_end_i),
    .y_end_i            (y_end_i),
    .rect_width_i       (rect_width_i),
    .rect_height_i      (rect_height_i),
    .colour_i           (colour_i),
    .read_row_i         (read_row_i),
    .read_byte_column_i (read_byte_column_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .read_data_o        (read_data_o),
    .done_res_o         (done_res_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Shadow frame store
  // ---------------------------------------------------------------------------

  function automatic void shadow_plot(int x, int y, logic colour);
    int idx;
    if (x < 0 || y < 0 || x >= DISPLAY_SIDE || y >= DISPLAY_SIDE) return;
    idx = y * ROW_BYTES + x / 8;
    shadow_frame[idx][x % 8] = colour;
  endfunction

  // All-octant Bresenham, both endpoints included
  function automatic void shadow_line(int x0, int y0, int x1, int y1, logic colour);
    int dx;
    int dy;
    int sx;
    int sy;
    int err;
    int e2;
    dx  = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    dy  = (y1 > y0) ? (y0 - y1) : (y1 - y0);
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    while (1) begin
      shadow_plot(x0, y0, colour);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        x0  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        y0  += sy;
      end
    end
  endfunction

  // Clip the rectangle first, then plot each column top to bottom
  function automatic void shadow_rect(int x, int y, int w, int h, logic colour);
    int xlo;
    int xhi;
    int ylo;
    int yhi;
    xlo = (x < 0) ? 0 : x;
    xhi = (x + w > DISPLAY_SIDE - 1) ? DISPLAY_SIDE - 1 : x + w;
    ylo = (h < 0) ? y + h : y;
    yhi = (h < 0) ? y : y + h;
    if (ylo < 0) ylo = 0;
    if (yhi > DISPLAY_SIDE - 1) yhi = DISPLAY_SIDE - 1;
    for (int xx = xlo; xx <= xhi; xx++) begin
      for (int yy = ylo; yy <= yhi; yy++) begin
        shadow_plot(xx, yy, colour);
      end
    end
  endfunction

  // Apply one request to the shadow store; return the byte it should report
  function automatic logic [7:0] apply_request(raster_cmd_t c);
    logic [7:0] data;
    int         row;
    int         col;
    data = 8'h00;
    row  = int'(c.read_row);
    col  = int'(c.read_byte_column);
    case (c.mode)
      MODE_LINE: begin
        shadow_line(int'(c.x_start), int'(c.y_start), int'(c.x_end), int'(c.y_end),
                    c.colour);
      end
      MODE_RECT: begin
        shadow_rect(int'(c.x_start), int'(c.y_start), int'(c.rect_width),
                    int'(c.rect_height), c.colour);
      end
      MODE_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'hFF;
      end
      default: begin
        if (row < DISPLAY_SIDE && col < ROW_BYTES) data = shadow_frame[row * ROW_BYTES + col];
      end
    endcase
    return data;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Idle at random, then hold the request until it is accepted
  task automatic issue_request(raster_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    mode_i             <= c.mode;
    x_start_i          <= c.x_start;
    y_start_i          <= c.y_start;
    x_end_i            <= c.x_end;
    y_end_i            <= c.y_end;
    rect_width_i       <= c.rect_width;
    rect_height_i      <= c.rect_height;
    colour_i           <= c.colour;
    read_row_i         <= c.read_row;
    read_byte_column_i <= c.read_byte_column;
    do @(posedge clk_i); while (!in_ready_o);
    owed_bytes.push_back(apply_request(c));
  endtask

  function automatic raster_cmd_t blank_request(mode_e mode);
    raster_cmd_t c;
    c.mode             = mode;
    c.x_start          = '0;
    c.y_start          = '0;
    c.x_end            = '0;
    c.y_end            = '0;
    c.rect_width       = '0;
    c.rect_height      = '0;
    c.colour           = 1'b0;
    c.read_row         = '0;
    c.read_byte_column = '0;
    return c;
  endfunction

  task automatic send_line(int x0, int y0, int x1, int y1, logic colour);
    raster_cmd_t c;
    c         = blank_request(MODE_LINE);
    c.x_start = CW'(x0);
    c.y_start = CW'(y0);
    c.x_end   = CW'(x1);
    c.y_end   = CW'(y1);
    c.colour  = colour;
    issue_request(c);
  endtask

  task automatic send_rect(int x, int y, int w, int h, logic colour);
    raster_cmd_t c;
    c             = blank_request(MODE_RECT);
    c.x_start     = CW'(x);
    c.y_start     = CW'(y);
    c.rect_width  = CW'(w);
    c.rect_height = CW'(h);
    c.colour      = colour;
    issue_request(c);
  endtask

  task automatic send_read(int row, int col);
    raster_cmd_t c;
    c                  = blank_request(MODE_READ);
    c.read_row         = 7'(row);
    c.read_byte_column = 4'(col);
    issue_request(c);
  endtask

  // Coordinate inside the current drawing window, spilling a little off it
  function automatic int window_coord(int origin);
    return origin + int'($urandom_range(48)) - 8;
  endfunction

  // Random request: mostly small shapes near the window, reads mostly inside it;
  // a big request uses full-range coordinates
  function automatic raster_cmd_t random_request(bit big);
    raster_cmd_t c;
    int          pick;
    int          row;
    int          col;
    c.mode             = MODE_READ;
    c.x_start          = CW'($urandom);
    c.y_start          = CW'($urandom);
    c.x_end            = CW'($urandom);
    c.y_end            = CW'($urandom);
    c.rect_width       = CW'($urandom);
    c.rect_height      = CW'($urandom);
    c.colour           = 1'($urandom);
    c.read_row         = 7'($urandom);
    c.read_byte_column = 4'($urandom);
    pick               = $urandom_range(99);
    if (pick < 30) begin
      c.mode = MODE_LINE;
      if (!big) begin
        c.x_start = CW'(window_coord(win_x));
        c.y_start = CW'(window_coord(win_y));
        c.x_end   = CW'(window_coord(win_x));
        c.y_end   = CW'(window_coord(win_y));
      end
    end else if (pick < 55) begin
      c.mode = MODE_RECT;
      if (!big) begin
        c.x_start     = CW'(window_coord(win_x));
        c.y_start     = CW'(window_coord(win_y));
        c.rect_width  = CW'(int'($urandom_range(24)) - 4);
        c.rect_height = CW'(int'($urandom_range(40)) - 20);
      end
    end else if (pick < 58) begin
      c.mode = MODE_CLEAR;
    end else if (pick < 90) begin
      row = win_y + int'($urandom_range(40));
      col = (win_x + int'($urandom_range(40))) / 8;
      c.read_row         = 7'((row > DISPLAY_SIDE - 1) ? DISPLAY_SIDE - 1 : row);
      c.read_byte_column = 4'((col > ROW_BYTES - 1) ? ROW_BYTES - 1 : col);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall at random or for a held-off stretch, check each result
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin : check_result
      logic [7:0] want;
      if (owed_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result, read_data %02h", read_data_o));
      end else begin
        want = owed_bytes.pop_front();
        if (read_data_o !== want)
          report_mismatch($sformatf("result %0d: read_data %02h, want %02h",
                                    result_count, read_data_o, want));
        if (done_res_o !== 1'b1)
          report_mismatch($sformatf("result %0d: done_res %b, want 1",
                                    result_count, done_res_o));
      end
      result_count++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_line_commands();
    send_read(0, 0);
    send_line(0, 0, 0, 0, 1'b0);                   // single pixel
    send_read(0, 0);
    send_line(0, 1, 15, 1, 1'b0);                  // horizontal across two bytes
    send_read(1, 1);
    send_line(-2048, -2048, 2047, 2047, 1'b0);     // full-range diagonal
    send_read(127, 15);
    send_line(130, -5, 3, 200, 1'b0);              // steep, clipped at both ends
    send_line(2047, -2048, -2048, 2047, 1'b1);     // never touches the display
    send_line(127, 0, 0, 127, 1'b1);
    send_read(0, 15);
  endtask

  task automatic test_rect_commands();
    send_rect(10, 10, -1, 5, 1'b0);                // negative width draws nothing
    send_read(10, 1);
    send_rect(5, 5, -2048, -2048, 1'b0);
    send_rect(16, 20, 7, -3, 1'b0);                // negative height runs upward
    send_read(17, 2);
    send_rect(-50, 0, 10, 10, 1'b0);               // fully off the display
    send_rect(0, 0, 2047, 2047, 1'b0);             // whole display
    send_read(64, 8);
    send_rect(127, 127, 0, 0, 1'b1);               // single corner pixel
    send_read(127, 15);
  endtask

  task automatic test_clear_command();
    issue_request(blank_request(MODE_CLEAR));
    send_read(64, 8);
  endtask

  // Hold the result side off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    int i;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 400;
    for (i = 0; i < 8; i++) begin
      if (i % 2 == 0) send_line(i, 3 * i, 20 - i, 40, i % 4 == 0);
      else send_read(3 * i, i);
    end
  endtask

  task automatic test_random_mix(int count, int idle_pct, int stall_pct);
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < count; i++) begin
      // move the drawing window now and then so reads cover the whole store
      if (i % 50 == 0) begin
        win_x = $urandom_range(100);
        win_y = $urandom_range(100);
      end
      issue_request(random_request(i % 40 == 20));
    end
  endtask

  initial begin
    int waited;
    foreach (shadow_frame[i]) shadow_frame[i] = 8'hFF;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_line_commands();
    test_rect_commands();
    test_clear_command();
    test_backpressure();
    test_random_mix(200, 0, 0);
    test_random_mix(200, 53, 0);
    test_random_mix(200, 0, 53);
    test_random_mix(200, 32, 32);

    // Drain outstanding results
    in_valid_i <= 1'b0;
    waited = 0;
    while (owed_bytes.size() != 0 && waited < 40000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (owed_bytes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", owed_bytes.size()));

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", owed_bytes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
